/* src/t32c_pkg.sv */
// Shared types, constants and group classifiers for the Thumb-2 32-bit word classifier.
package t32c_pkg;

    localparam int INSN_W  = 32;
    localparam int CLASS_W = 4;

    localparam logic [3:0] REG_SP = 4'hd;
    localparam logic [3:0] REG_PC = 4'hf;

    // Exact MRS encoding that is accepted; bits 11..8 (Rd) are masked off
    localparam logic [31:0] MRS_MASK  = 32'hffff_f0ff;
    localparam logic [31:0] MRS_MATCH = 32'hf3ef_8000;

    // Branch/misc group op values with a special meaning
    localparam logic [6:0] BR_OP_MSR  = 7'b0111000;
    localparam logic [6:0] BR_OP_HINT = 7'b0111010;
    localparam logic [6:0] BR_OP_MRS  = 7'b0111110;

    typedef enum logic [CLASS_W-1:0] {
        CLS_REJECT  = 4'd0,
        CLS_GENERIC = 4'd1,
        CLS_ADR_T3  = 4'd2,
        CLS_ADR_T2  = 4'd3,
        CLS_NOP     = 4'd4,
        CLS_B_T3    = 4'd5,
        CLS_B_T4    = 4'd6,
        CLS_BLX_T2  = 4'd7,
        CLS_BL_T1   = 4'd8,
        CLS_LDR_LIT = 4'd9
    } cls_t;

    typedef enum logic [3:0] {
        GRP_NONE   = 4'd0,
        GRP_MIM    = 4'd1,
        GRP_IMM    = 4'd2,
        GRP_BRANCH = 4'd3,
        GRP_LDM    = 4'd4,
        GRP_SHR    = 4'd5,
        GRP_STR    = 4'd6,
        GRP_LDR    = 4'd7,
        GRP_REG    = 4'd8,
        GRP_MUL    = 4'd9,
        GRP_MULL   = 4'd10
    } grp_t;

    // Register-field checks worked out in the first stage
    typedef struct packed {
        logic rn_sp;
        logic rn_pc;
        logic rd_sp;
        logic rd_pc;
        logic rm_sp;
        logic rm_pc;
        logic rt_sp;
        logic rt_pc;
        logic rn_eq_rt;
        logic multi_reg;
        logic rn_listed;
    } reg_flags_t;

    typedef struct packed {
        logic [INSN_W-1:0] word;
        grp_t              grp;
        reg_flags_t        flags;
    } s1_t;

    typedef struct packed {
        grp_t grp;
        cls_t res_mim;
        cls_t res_imm;
        cls_t res_branch;
        cls_t res_ldm;
        cls_t res_shr;
        cls_t res_str;
        cls_t res_ldr;
        cls_t res_reg;
        cls_t res_mul;
        cls_t res_mull;
    } s2_t;

    function automatic cls_t gen_or_rej(input logic rej);
        return rej ? CLS_REJECT : CLS_GENERIC;
    endfunction

    // Data processing, modified immediate
    function automatic cls_t cls_mim(input logic [31:0] w, input reg_flags_t f);
        logic [3:0] op;
        logic       s;
        logic       rn_bad;
        logic       rd_bad;
        cls_t       res;
        op     = w[24:21];
        s      = w[20];
        rn_bad = f.rn_sp | f.rn_pc;
        rd_bad = f.rd_sp | f.rd_pc;
        case (op) inside
            4'd0, 4'd4, 4'd8, 4'd13: res = gen_or_rej(rn_bad || (f.rd_pc && !s) || f.rd_sp);
            4'd1, 4'd10, 4'd11, 4'd14: res = gen_or_rej(rd_bad || rn_bad);
            4'd2, 4'd3:              res = gen_or_rej(rd_bad || f.rn_sp);
            default:                 res = CLS_REJECT;
        endcase
        return res;
    endfunction

    // Data processing, plain binary immediate
    function automatic cls_t cls_imm(input logic [31:0] w, input reg_flags_t f);
        logic [4:0] op;
        cls_t       res;
        op = w[24:20];
        if (f.rd_sp || f.rd_pc)
            res = CLS_REJECT;
        else if (op == 5'd0 || op == 5'd10)
        begin
            if (f.rn_pc)
                res = (op == 5'd0) ? CLS_ADR_T3 : CLS_ADR_T2;
            else
                res = CLS_GENERIC;
        end
        else if (op[2:0] == 3'd4 || (op & 5'h15) == 5'h10)
            res = gen_or_rej(f.rn_sp || f.rn_pc);
        else if (op == 5'd22)
            res = gen_or_rej(f.rn_sp);
        else
            res = CLS_REJECT;
        return res;
    endfunction

    // Branches and miscellaneous control
    function automatic cls_t cls_branch(input logic [31:0] w, input reg_flags_t f);
        logic [6:0] op;
        logic [2:0] op1;
        cls_t       res;
        op  = w[26:20];
        op1 = w[14:12];
        if (op1[0])
            res = op1[2] ? CLS_BL_T1 : CLS_B_T4;
        else if (op1[2])
            res = CLS_BLX_T2;
        else if (op == BR_OP_MSR)
            res = gen_or_rej(w[9:8] != 2'b00 || f.rn_sp || f.rn_pc);
        else if (op == BR_OP_HINT)
            res = (w[10:8] == 3'b000) ? CLS_NOP : CLS_REJECT;
        else if (op == BR_OP_MRS)
            res = gen_or_rej((w & MRS_MASK) != MRS_MATCH || f.rd_sp || f.rd_pc);
        else if (op[5:3] == 3'b111)
            res = CLS_REJECT;
        else
            res = CLS_B_T3;
        return res;
    endfunction

    // Load/store multiple
    function automatic cls_t cls_ldm(input logic [31:0] w, input reg_flags_t f);
        logic [1:0] op;
        cls_t       res;
        op = w[24:23];
        if (op == 2'd0 || op == 2'd3 || !f.multi_reg || f.rn_pc)
            res = CLS_REJECT;
        else if (w[20] && ((w[15] && w[14]) || w[13]))
            res = CLS_REJECT;
        else if (!w[20] && (w[15] || w[13]))
            res = CLS_REJECT;
        else
            res = gen_or_rej(w[21] && f.rn_listed);
        return res;
    endfunction

    // Data processing, shifted register
    function automatic cls_t cls_shr(input logic [31:0] w, input reg_flags_t f);
        logic [3:0] op;
        logic       s;
        logic       rn_bad;
        logic       rd_bad;
        logic       rm_bad;
        cls_t       res;
        op     = w[24:21];
        s      = w[20];
        rn_bad = f.rn_sp | f.rn_pc;
        rd_bad = f.rd_sp | f.rd_pc;
        rm_bad = f.rm_sp | f.rm_pc;
        case (op) inside
            4'd0, 4'd4, 4'd8, 4'd13:
                res = gen_or_rej(rn_bad || rm_bad || (f.rd_pc && !s) || f.rd_sp);
            4'd1, 4'd6, 4'd10, 4'd11, 4'd14:
                res = gen_or_rej(rd_bad || rm_bad || rn_bad);
            4'd2, 4'd3:
                res = gen_or_rej(rd_bad || rm_bad || f.rn_sp);
            default:
                res = CLS_REJECT;
        endcase
        return res;
    endfunction

    // Single store
    function automatic cls_t cls_str(input logic [31:0] w, input reg_flags_t f);
        logic [2:0] op1;
        logic [5:0] op2;
        logic       rt_rej;
        cls_t       res;
        op1    = w[23:21];
        op2    = w[11:6];
        rt_rej = (op1[1:0] == 2'd2) ? f.rt_pc : (f.rt_sp | f.rt_pc);
        if (f.rn_pc || rt_rej)
            res = CLS_REJECT;
        else if (op1 < 3'd3)
        begin
            if (op2 == 6'd0)
                res = gen_or_rej(f.rm_sp || f.rm_pc);
            else if ((op2 & 6'h24) == 6'h24 || (op2 & 6'h30) == 6'h30)
                res = gen_or_rej((!w[10] && !w[8]) || (w[8] && f.rn_eq_rt));
            else
                res = CLS_REJECT;
        end
        else if (op1 >= 3'd4 && op1 <= 3'd6)
            res = CLS_GENERIC;
        else
            res = CLS_REJECT;
        return res;
    endfunction

    // Single word load
    function automatic cls_t cls_ldr(input logic [31:0] w, input reg_flags_t f);
        logic [1:0] op1;
        logic [5:0] op2;
        logic       p;
        logic       u;
        logic       wb;
        cls_t       res;
        op1 = w[24:23];
        op2 = w[11:6];
        p   = w[10];
        u   = w[9];
        wb  = w[8];
        if (op1[1])
            res = CLS_REJECT;
        else if (f.rn_pc)
            res = f.rt_pc ? CLS_REJECT : CLS_LDR_LIT;
        else if (op1 == 2'd0 && op2 == 6'd0)
            res = gen_or_rej(f.rm_sp || f.rm_pc);
        else if (op1 == 2'd1)
            res = CLS_GENERIC;
        else if ((op2 & 6'h24) == 6'h24 || (op2 & 6'h3c) == 6'h30)
            res = gen_or_rej((!p && !wb) || (wb && f.rn_eq_rt)
                             || (p && u && !wb && (f.rt_sp || f.rt_pc)));
        else
            res = CLS_REJECT;
        return res;
    endfunction

    // Data processing, register
    function automatic cls_t cls_reg(input logic [31:0] w, input reg_flags_t f);
        logic [3:0] op1;
        logic [3:0] op2;
        logic       rd_bad;
        logic       rm_bad;
        logic       any_bad;
        cls_t       res;
        op1     = w[23:20];
        op2     = w[7:4];
        rd_bad  = f.rd_sp | f.rd_pc;
        rm_bad  = f.rm_sp | f.rm_pc;
        any_bad = rd_bad | rm_bad | f.rn_sp | f.rn_pc;
        if (w[15:12] != 4'hf)
            res = CLS_REJECT;
        else if (!op1[3] && op2 == 4'd0)
            res = gen_or_rej(any_bad);
        else if (op2[3] && op1 <= 4'd5)
            res = gen_or_rej(rd_bad || rm_bad);
        else if (op1[3] && !op2[3])
            res = gen_or_rej(op2[1:0] == 2'd3 || op1[1:0] == 2'd3 || any_bad);
        else if (op1[3:2] == 2'd2 && op2[3:2] == 2'd2)
            res = gen_or_rej((op1[1] && op2[1:0] != 2'd0) || any_bad);
        else
            res = CLS_REJECT;
        return res;
    endfunction

    // Multiply and multiply-accumulate
    function automatic cls_t cls_mul(input logic [31:0] w, input reg_flags_t f);
        logic [4:0] op12;
        cls_t       res;
        op12 = {w[22:20], w[5:4]};
        if (w[7:6] != 2'd0 || f.rn_pc || f.rm_pc || f.rt_pc || f.rd_pc)
            res = CLS_REJECT;
        else if (((op12 & 5'h1c) == 5'h04 || !op12[1]) && op12 != 5'h1d)
            res = CLS_GENERIC;
        else
            res = CLS_REJECT;
        return res;
    endfunction

    // Long multiply and divide
    function automatic cls_t cls_mull(input logic [31:0] w, input reg_flags_t f);
        logic [6:0] op12;
        cls_t       res;
        op12 = {w[22:20], w[7:4]};
        if (f.rn_pc || f.rm_pc || f.rt_pc || f.rd_pc)
            res = CLS_REJECT;
        else if ((op12 & 7'h6e) == 7'h46 || op12 == 7'h66 || (op12 & 7'h7c) == 7'h48
                 || (op12 & 7'h1f) == 7'h00 || (op12 & 7'h5f) == 7'h1f)
            res = CLS_GENERIC;
        else
            res = CLS_REJECT;
        return res;
    endfunction

endpackage

/* src/t32c_if.sv */
// Valid/ready channel interfaces for the instruction and result words.
interface t32c_insn_if;
    import t32c_pkg::*;

    logic              valid;
    logic              ready;
    logic [INSN_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

interface t32c_class_if;
    import t32c_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] template_class;

    modport source (output valid, output template_class, input ready);
    modport sink (input valid, input template_class, output ready);
endinterface

/* src/t32c_predecode.sv */
// First stage: encoding group select and register-field checks.
module t32c_predecode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [t32c_pkg::INSN_W-1:0] word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output t32c_pkg::s1_t              out_data
);
    import t32c_pkg::*;

    logic       valid_reg;
    s1_t        data_reg;
    s1_t        data_next;
    grp_t       grp;
    logic [6:0] op2;
    logic [15:0] regs;

    assign op2  = word[26:20];
    assign regs = word[15:0];

    always_comb
    begin
        grp = GRP_NONE;
        if (word[31:29] == 3'b111)
        begin
            unique case (word[28:27])
                2'b01:
                begin
                    if (op2[6])
                        grp = GRP_NONE;
                    else if (op2[6:5] == 2'b01)
                        grp = GRP_SHR;
                    else if ((op2 & 7'h64) == 7'h00)
                        grp = GRP_LDM;
                    else
                        grp = GRP_NONE;
                end
                2'b10:
                begin
                    if (word[15])
                        grp = GRP_BRANCH;
                    else
                        grp = op2[5] ? GRP_IMM : GRP_MIM;
                end
                2'b11:
                begin
                    if ((op2 & 7'h71) == 7'h00)
                        grp = GRP_STR;
                    else if ((op2 & 7'h67) == 7'h05)
                        grp = GRP_LDR;
                    else if ((op2 & 7'h70) == 7'h20)
                        grp = GRP_REG;
                    else if ((op2 & 7'h78) == 7'h30)
                        grp = GRP_MUL;
                    else if ((op2 & 7'h78) == 7'h38)
                        grp = GRP_MULL;
                    else
                        grp = GRP_NONE;
                end
                default:
                    grp = GRP_NONE;
            endcase
        end
    end

    always_comb
    begin
        data_next.word            = word;
        data_next.grp             = grp;
        data_next.flags.rn_sp     = (word[19:16] == REG_SP);
        data_next.flags.rn_pc     = (word[19:16] == REG_PC);
        data_next.flags.rd_sp     = (word[11:8] == REG_SP);
        data_next.flags.rd_pc     = (word[11:8] == REG_PC);
        data_next.flags.rm_sp     = (word[3:0] == REG_SP);
        data_next.flags.rm_pc     = (word[3:0] == REG_PC);
        data_next.flags.rt_sp     = (word[15:12] == REG_SP);
        data_next.flags.rt_pc     = (word[15:12] == REG_PC);
        data_next.flags.rn_eq_rt  = (word[19:16] == word[15:12]);
        // two or more bits set: clearing the lowest one leaves something
        data_next.flags.multi_reg = (regs & (regs - 16'd1)) != 16'd0;
        data_next.flags.rn_listed = regs[word[19:16]];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* src/t32c_group_eval.sv */
// Second stage: classify the word under every encoding group in parallel.
module t32c_group_eval (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  t32c_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output t32c_pkg::s2_t out_data
);
    import t32c_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    always_comb
    begin
        data_next.grp        = in_data.grp;
        data_next.res_mim    = cls_mim(in_data.word, in_data.flags);
        data_next.res_imm    = cls_imm(in_data.word, in_data.flags);
        data_next.res_branch = cls_branch(in_data.word, in_data.flags);
        data_next.res_ldm    = cls_ldm(in_data.word, in_data.flags);
        data_next.res_shr    = cls_shr(in_data.word, in_data.flags);
        data_next.res_str    = cls_str(in_data.word, in_data.flags);
        data_next.res_ldr    = cls_ldr(in_data.word, in_data.flags);
        data_next.res_reg    = cls_reg(in_data.word, in_data.flags);
        data_next.res_mul    = cls_mul(in_data.word, in_data.flags);
        data_next.res_mull   = cls_mull(in_data.word, in_data.flags);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

/* src/t32c_select.sv */
// Third stage: pick the class of the decoded group into the output register.
module t32c_select (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  t32c_pkg::s2_t                in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [t32c_pkg::CLASS_W-1:0] out_class
);
    import t32c_pkg::*;

    logic valid_reg;
    cls_t class_reg;
    cls_t class_next;

    always_comb
    begin
        unique case (in_data.grp)
            GRP_MIM:    class_next = in_data.res_mim;
            GRP_IMM:    class_next = in_data.res_imm;
            GRP_BRANCH: class_next = in_data.res_branch;
            GRP_LDM:    class_next = in_data.res_ldm;
            GRP_SHR:    class_next = in_data.res_shr;
            GRP_STR:    class_next = in_data.res_str;
            GRP_LDR:    class_next = in_data.res_ldr;
            GRP_REG:    class_next = in_data.res_reg;
            GRP_MUL:    class_next = in_data.res_mul;
            GRP_MULL:   class_next = in_data.res_mull;
            default:    class_next = CLS_REJECT;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_class = class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            class_reg <= class_next;
    end

endmodule

/* src/thumb32_instruction_classifier.sv */
// Each word passes through three registered stages, predecode, group evaluation and
// select, before its class shows on the result channel. Throughput: one word per
// cycle while the result channel is ready; each of the three stages holds one word.
// A stage passes its word on when the next one is empty or draining, so a
// stalled result channel backs the pipeline up one stage at a time.
// Reset clears the stage valid bits only; the stage data registers are not reset.
module thumb32_instruction_classifier (
    input logic         clk,
    input logic         rst_n,
    t32c_insn_if.sink   insn,
    t32c_class_if.source result
);
    import t32c_pkg::*;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    t32c_predecode u_predecode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (insn.valid),
        .in_ready  (insn.ready),
        .word      (insn.instruction),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    t32c_group_eval u_group_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    t32c_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_class (result.template_class)
    );

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_ready |=> s1_valid && $stable(s1_data))
        else $error("stage 1 word changed while stalled");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
        else $error("stage 2 word changed while stalled");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        insn.valid && insn.ready |=> s1_valid)
        else $error("accepted word did not reach stage 1");

    a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && s2_ready |=> result.valid)
        else $error("stage 2 word did not reach the result register");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.template_class <= CLS_LDR_LIT)
        else $error("result class out of range");
`endif

endmodule

/* tb/sv/tb_thumb32_instruction_classifier.sv */
// Testbench for the Thumb-2 32-bit word classifier: random and directed words, each result checked per word.
module tb_thumb32_instruction_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import t32c_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] word;
        cls_t        cls;
    } pending_class_t;

    class class_ledger;
        localparam logic [3:0] R_SP    = 4'hd;
        localparam logic [3:0] R_PC    = 4'hf;
        localparam logic [6:0] OP_MSR  = 7'h38;
        localparam logic [6:0] OP_HINT = 7'h3a;
        localparam logic [6:0] OP_MRS  = 7'h3e;

        pending_class_t pending[$];
        int             errors;

        function automatic cls_t generic_if_clean(logic broken);
            return broken ? CLS_REJECT : CLS_GENERIC;
        endfunction

        function automatic logic sp_or_pc(logic [3:0] r);
            return r == R_SP || r == R_PC;
        endfunction

        function automatic cls_t thumb_class_of(logic [31:0] x);
            logic [1:0] top_op;
            logic [6:0] grp_op;
            logic [3:0] rn;
            logic [3:0] rd;
            logic [3:0] rm;
            logic [3:0] rt;
            logic       rn_bad;
            logic       rd_bad;
            logic       rm_bad;
            logic       rt_bad;
            logic       any_bad;
            logic [3:0] op4;
            logic [4:0] op5;
            logic [2:0] op3;
            logic [5:0] op6;
            logic [3:0] opb;
            logic [6:0] op7;
            cls_t       c;
            top_op  = x[28:27];
            grp_op  = x[26:20];
            rn      = x[19:16];
            rt      = x[15:12];
            rd      = x[11:8];
            rm      = x[3:0];
            rn_bad  = sp_or_pc(rn);
            rd_bad  = sp_or_pc(rd);
            rm_bad  = sp_or_pc(rm);
            rt_bad  = sp_or_pc(rt);
            any_bad = rn_bad || rd_bad || rm_bad;
            c       = CLS_REJECT;
            if (x[31:29] != 3'b111 || top_op == 2'd0)
                c = CLS_REJECT;
            else if (top_op == 2'd1)
            begin
                if (grp_op[6])
                    c = CLS_REJECT;
                else if (grp_op[6:5] == 2'b01)
                begin
                    // shifted-register data processing
                    op4 = x[24:21];
                    case (op4)
                        4'd0, 4'd4, 4'd8, 4'd13:
                            c = generic_if_clean(rn_bad || rm_bad || (rd == R_PC && !x[20])
                                                 || rd == R_SP);
                        4'd1, 4'd6, 4'd10, 4'd11, 4'd14:
                            c = generic_if_clean(rd_bad || rm_bad || rn_bad);
                        4'd2, 4'd3:
                            c = generic_if_clean(rd_bad || rm_bad || rn == R_SP);
                        default:
                            c = CLS_REJECT;
                    endcase
                end
                else if ((grp_op & 7'h64) == 7'h00)
                begin
                    // load/store multiple
                    if (x[24:23] == 2'd0 || x[24:23] == 2'd3)
                        c = CLS_REJECT;
                    else if ($countones(x[15:0]) < 2 || rn == R_PC)
                        c = CLS_REJECT;
                    else if (x[20] && ((x[15] && x[14]) || x[13]))
                        c = CLS_REJECT;
                    else if (!x[20] && (x[15] || x[13]))
                        c = CLS_REJECT;
                    else
                        c = generic_if_clean(x[21] && x[rn]);
                end
            end
            else if (top_op == 2'd2)
            begin
                if (x[15])
                begin
                    op7 = grp_op;
                    op3 = x[14:12];
                    opb = x[11:8];
                    if (op3[0])
                        c = op3[2] ? CLS_BL_T1 : CLS_B_T4;
                    else if (op3[2])
                        c = CLS_BLX_T2;
                    else if (op7 == OP_MSR)
                        c = generic_if_clean(opb[1:0] != 2'd0 || rn_bad);
                    else if (op7 == OP_HINT)
                        c = (x[10:8] == 3'd0) ? CLS_NOP : CLS_REJECT;
                    else if (op7 == OP_MRS)
                        c = generic_if_clean((x & 32'hffff_f0ff) != 32'hf3ef_8000 || rd_bad);
                    else if (op7[5:3] == 3'b111)
                        c = CLS_REJECT;
                    else
                        c = CLS_B_T3;
                end
                else if (grp_op[5])
                begin
                    // plain binary immediate
                    op5 = x[24:20];
                    if (rd_bad)
                        c = CLS_REJECT;
                    else if (op5 == 5'd0 || op5 == 5'd10)
                    begin
                        if (rn == R_PC)
                            c = (op5 == 5'd0) ? CLS_ADR_T3 : CLS_ADR_T2;
                        else
                            c = CLS_GENERIC;
                    end
                    else if (op5[2:0] == 3'd4 || (op5 & 5'h15) == 5'h10)
                        c = generic_if_clean(rn_bad);
                    else if (op5 == 5'd22)
                        c = generic_if_clean(rn == R_SP);
                    else
                        c = CLS_REJECT;
                end
                else
                begin
                    // modified immediate
                    op4 = x[24:21];
                    case (op4)
                        4'd0, 4'd4, 4'd8, 4'd13:
                            c = generic_if_clean(rn_bad || (rd == R_PC && !x[20]) || rd == R_SP);
                        4'd1, 4'd10, 4'd11, 4'd14:
                            c = generic_if_clean(rd_bad || rn_bad);
                        4'd2, 4'd3:
                            c = generic_if_clean(rd_bad || rn == R_SP);
                        default:
                            c = CLS_REJECT;
                    endcase
                end
            end
            else if ((grp_op & 7'h71) == 7'h00)
            begin
                // single store
                op3 = x[23:21];
                op6 = x[11:6];
                if (rn == R_PC)
                    c = CLS_REJECT;
                else if ((op3[1:0] == 2'd2) ? rt == R_PC : rt_bad)
                    c = CLS_REJECT;
                else if (op3 < 3'd3)
                begin
                    if (op6 == 6'd0)
                        c = generic_if_clean(rm_bad);
                    else if ((op6 & 6'h24) == 6'h24 || (op6 & 6'h30) == 6'h30)
                        c = generic_if_clean((!x[10] && !x[8]) || (x[8] && rn == rt));
                    else
                        c = CLS_REJECT;
                end
                else if (op3 >= 3'd4 && op3 <= 3'd6)
                    c = CLS_GENERIC;
                else
                    c = CLS_REJECT;
            end
            else if ((grp_op & 7'h67) == 7'h05)
            begin
                // single word load
                op6 = x[11:6];
                if (x[24])
                    c = CLS_REJECT;
                else if (rn == R_PC)
                    c = (rt == R_PC) ? CLS_REJECT : CLS_LDR_LIT;
                else if (!x[23] && op6 == 6'd0)
                    c = generic_if_clean(rm_bad);
                else if (x[23])
                    c = CLS_GENERIC;
                else if ((op6 & 6'h24) == 6'h24 || (op6 & 6'h3c) == 6'h30)
                    c = generic_if_clean((!x[10] && !x[8]) || (x[8] && rn == rt)
                                         || (x[10] && x[9] && !x[8] && rt_bad));
                else
                    c = CLS_REJECT;
            end
            else if ((grp_op & 7'h70) == 7'h20)
            begin
                // register data processing: op4 is op1, opb is op2
                op4 = x[23:20];
                opb = x[7:4];
                if (rt != 4'hf)
                    c = CLS_REJECT;
                else if (op4 < 4'd8 && opb == 4'd0)
                    c = generic_if_clean(any_bad);
                else if (opb[3] && op4 <= 4'd5)
                    c = generic_if_clean(rd_bad || rm_bad);
                else if (op4[3] && !opb[3])
                    c = generic_if_clean(opb[1:0] == 2'd3 || op4[1:0] == 2'd3 || any_bad);
                else if (op4[3:2] == 2'd2 && opb[3:2] == 2'd2)
                    c = generic_if_clean((op4[1] && opb[1:0] != 2'd0) || any_bad);
                else
                    c = CLS_REJECT;
            end
            else if ((grp_op & 7'h78) == 7'h30)
            begin
                op5 = {x[22:20], x[5:4]};
                if (x[7:6] != 2'd0)
                    c = CLS_REJECT;
                else if (rn == R_PC || rm == R_PC || rt == R_PC || rd == R_PC)
                    c = CLS_REJECT;
                else if (((op5 & 5'h1c) == 5'h04 || !op5[1]) && op5 != 5'h1d)
                    c = CLS_GENERIC;
                else
                    c = CLS_REJECT;
            end
            else if ((grp_op & 7'h78) == 7'h38)
            begin
                // long multiply: op is bits 22..20 above bits 7..4
                op7 = {x[22:20], x[7:4]};
                if (rn == R_PC || rm == R_PC || rt == R_PC || rd == R_PC)
                    c = CLS_REJECT;
                else if ((op7 & 7'h6e) == 7'h46 || op7 == 7'h66 || (op7 & 7'h7c) == 7'h48
                         || (op7 & 7'h1f) == 7'h00 || (op7 & 7'h5f) == 7'h1f)
                    c = CLS_GENERIC;
                else
                    c = CLS_REJECT;
            end
            return c;
        endfunction

        task report(string what, logic [31:0] word, logic [3:0] want, logic [3:0] got);
            errors++;
            $display("MISMATCH %s: word=%h want=%0d got=%0d", what, word, want, got);
        endtask

        function void note_word(logic [31:0] word);
            pending_class_t p;
            p.word = word;
            p.cls  = thumb_class_of(word);
            pending.push_back(p);
        endfunction

        task check_class(logic [3:0] got);
            pending_class_t p;
            if (pending.size() == 0)
                report("class with no word pending", 32'h0, 4'h0, got);
            else
            begin
                p = pending.pop_front();
                if (got !== p.cls)
                    report("template_class", p.word, p.cls, got);
            end
        endtask
    endclass

    localparam logic [31:0] FIXED_WORDS [24] = '{
        32'h0000_0000, 32'hffff_ffff, 32'he7ff_ffff, 32'hdfff_ffff,
        32'hf041_0200, 32'hf04f_0200, 32'hea61_0203, 32'hea6f_0203,
        32'hf3af_8000, 32'hf3af_8100, 32'hf3c0_8000, 32'hf7f0_8000,
        32'hf000_8000, 32'hf000_9000, 32'hf000_d000, 32'hf000_c000,
        32'hf380_8800, 32'hf3ef_8300, 32'hf20f_0100, 32'hf2af_0100,
        32'hf8df_1000, 32'he890_0006, 32'hfbb1_f2f3, 32'hf891_0000
    };

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    int   quiet_cycles = 0;
    int   stall_left;

    class_ledger ledger;

    t32c_insn_if  insn_ch ();
    t32c_class_if class_ch ();

    thumb32_instruction_classifier u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .insn   (insn_ch),
        .result (class_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random word biased toward SP/PC register fields and toward each decode group
    function automatic logic [31:0] make_thumb_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 3) == 0) w[19:16] = $urandom_range(0, 1) ? 4'hd : 4'hf;
            if ($urandom_range(0, 3) == 0) w[15:12] = $urandom_range(0, 1) ? 4'hd : 4'hf;
            if ($urandom_range(0, 3) == 0) w[11:8]  = $urandom_range(0, 1) ? 4'hd : 4'hf;
            if ($urandom_range(0, 3) == 0) w[3:0]   = $urandom_range(0, 1) ? 4'hd : 4'hf;
            if ($urandom_range(0, 7) == 0) w[15:12] = w[19:16];
            w[31:29] = 3'b111;
            case ($urandom_range(1, 10))
                1:
                begin
                    w[28:27] = 2'b10;
                    w[25]    = 1'b0;
                    w[15]    = 1'b0;
                end
                2:
                begin
                    w[28:27] = 2'b10;
                    w[25]    = 1'b1;
                    w[15]    = 1'b0;
                end
                3:
                begin
                    w[28:27] = 2'b10;
                    w[15]    = 1'b1;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        w[14] = 1'b0;
                        w[12] = 1'b0;
                    end
                    case ($urandom_range(0, 4))
                        0: w[26:20] = 7'h38;
                        1: w[26:20] = 7'h3a;
                        2: w = {16'hf3ef, 1'b1, w[14:12], w[11:8], 8'h00};
                        default: ;
                    endcase
                end
                4:
                begin
                    w[28:27] = 2'b01;
                    w[26:25] = 2'b00;
                    w[22]    = 1'b0;
                    w[15:0]  = $urandom_range(0, 1) ? 16'($urandom & $urandom)
                                                    : 16'($urandom & $urandom & $urandom);
                end
                5:
                begin
                    w[28:27] = 2'b01;
                    w[26:25] = 2'b01;
                end
                6:
                begin
                    w[28:27] = 2'b11;
                    w[26:24] = 3'b000;
                    w[20]    = 1'b0;
                end
                7:
                begin
                    w[28:27] = 2'b11;
                    w[26:25] = 2'b00;
                    w[22:20] = 3'b101;
                    if ($urandom_range(0, 2) != 0) w[24] = 1'b0;
                end
                8:
                begin
                    w[28:27] = 2'b11;
                    w[26:24] = 3'b010;
                    if ($urandom_range(0, 7) != 0) w[15:12] = 4'hf;
                end
                9:
                begin
                    w[28:27] = 2'b11;
                    w[26:23] = 4'b0110;
                    if ($urandom_range(0, 3) != 0) w[7:6] = 2'b00;
                end
                default:
                begin
                    w[28:27] = 2'b11;
                    w[26:23] = 4'b0111;
                end
            endcase
        end
        return w;
    endfunction

    // Entered and left at a falling edge
    task automatic send_word(logic [31:0] w);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            insn_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        insn_ch.valid       <= 1'b1;
        insn_ch.instruction <= w;
        do
            @(posedge clk);
        while (!insn_ch.ready);
        ledger.note_word(w);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        insn_ch.valid <= 1'b0;
        while (ledger.pending.size() != 0)
            @(negedge clk);
    endtask

    // Result side: random stall bursts
    initial
    begin
        class_ch.ready = 1'b0;
        stall_left     = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                class_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                class_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
                class_ch.ready <= 1'b1;
        end
    end

    // Score results and watch for a stuck pipeline
    always @(posedge clk)
    begin
        if (rst_n && class_ch.valid && class_ch.ready)
            ledger.check_class(class_ch.template_class);
        if ((insn_ch.valid && insn_ch.ready) || (class_ch.valid && class_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        ledger              = new;
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        insn_ch.valid       = 1'b0;
        insn_ch.instruction = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (FIXED_WORDS[i])
            send_word(FIXED_WORDS[i]);
        wait_for_results();

        for (int seg = 0; seg < 9; seg++)
        begin
            // no idling in the last two segments
            idle_on = (seg < 7) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 50; k++)
                send_word(make_thumb_word());
            if (seg == 3)
                wait_for_results();
        end

        wait_for_results();
        repeat (6) @(negedge clk);
        if (ledger.pending.size() != 0)
            ledger.report("word left without class", ledger.pending[0].word,
                          ledger.pending[0].cls, 4'h0);
        if (ledger.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
src/t32c_pkg.sv
src/t32c_if.sv
src/t32c_predecode.sv
src/t32c_group_eval.sv
src/t32c_select.sv
src/thumb32_instruction_classifier.sv
tb/sv/tb_thumb32_instruction_classifier.sv
